/* src/pspu_pkg.sv */
package pspu_pkg;

	// Palette store depth and address width
	localparam int PAL_DEPTH = 256;
	localparam int PAL_IDX_W = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;

	// Queue depths
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);

	// PNG color types
	localparam logic [2:0] CT_GRAY = 3'd0;
	localparam logic [2:0] CT_RGB  = 3'd2;
	localparam logic [2:0] CT_PAL  = 3'd3;
	localparam logic [2:0] CT_GA   = 3'd4;
	localparam logic [2:0] CT_RGBA = 3'd6;

	// Bit depths
	localparam logic [4:0] BD_1  = 5'd1;
	localparam logic [4:0] BD_2  = 5'd2;
	localparam logic [4:0] BD_4  = 5'd4;
	localparam logic [4:0] BD_8  = 5'd8;
	localparam logic [4:0] BD_16 = 5'd16;

	// Input operations
	localparam logic OP_PAL_WRITE = 1'b0;
	localparam logic OP_ROW_BYTE  = 1'b1;

	typedef enum logic [2:0] {
		CFG_COLOR_TYPE = 3'd0,
		CFG_BIT_DEPTH  = 3'd1,
		CFG_KEY_ENABLE = 3'd2,
		CFG_KEY_RED    = 3'd3,
		CFG_KEY_GREEN  = 3'd4,
		CFG_KEY_BLUE   = 3'd5,
		CFG_SWAP_RB    = 3'd6,
		CFG_ROW_PIXELS = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CMD_PAL_WR  = 2'd0,
		CMD_SUBBYTE = 2'd1,
		CMD_PIXEL   = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		logic [2:0]  pix_type;
		logic [4:0]  sample_bits;
		logic        key_enable;
		logic [15:0] key_red;
		logic [15:0] key_green;
		logic [15:0] key_blue;
		logic        swap_red_blue;
		logic [15:0] row_pixels;
	} cfg_t;

	// One queued command: palette write {index, rgba}, one sub-byte row byte,
	// or a complete gathered pixel (newest byte in the low bits)
	typedef struct packed {
		cmd_kind_t   kind;
		logic [63:0] data;
	} cmd_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       row_end;
	} pix_t;

	// Unknown color types decode as gray
	function automatic logic [2:0] eff_type(input logic [2:0] ct);
		logic [2:0] r;
		case (ct)
			CT_GRAY, CT_RGB, CT_PAL, CT_GA, CT_RGBA: r = ct;
			default: r = CT_GRAY;
		endcase
		return r;
	endfunction

	// Unknown depths decode as 8; palette never runs at 16
	function automatic logic [4:0] eff_depth(input logic [2:0] ct, input logic [4:0] bd);
		logic [4:0] r;
		case (bd)
			BD_1, BD_2, BD_4, BD_8: r = bd;
			BD_16: r = (ct == CT_PAL) ? BD_8 : BD_16;
			default: r = BD_8;
		endcase
		return r;
	endfunction

	// Bytes per pixel at depth 8 or 16
	function automatic logic [3:0] bytes_per_pixel(input logic [2:0] ct, input logic [4:0] d);
		logic [3:0] ch;
		case (ct)
			CT_RGB:  ch = 4'd3;
			CT_GA:   ch = 4'd2;
			CT_RGBA: ch = 4'd4;
			default: ch = 4'd1;
		endcase
		return (d == BD_16) ? {ch[2:0], 1'b0} : ch;
	endfunction

endpackage

/* src/pspu_front.sv */
module pspu_front import pspu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        accept,
	input  logic        operation,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  palette_index,
	input  logic [31:0] palette_rgba,
	output logic        cmd_push,
	output cmd_t        cmd
);

	logic [63:0] gather_q;
	logic [2:0]  gcount_q;
	logic [2:0]  ct;
	logic [4:0]  d;
	logic [3:0]  bpp;
	logic [3:0]  ncount;
	logic [63:0] ngather;
	logic        sub_byte;

	always_comb begin
		ct       = eff_type(cfg.pix_type);
		d        = eff_depth(ct, cfg.sample_bits);
		bpp      = bytes_per_pixel(ct, d);
		sub_byte = (d == BD_1) || (d == BD_2) || (d == BD_4);
		ncount   = {1'b0, gcount_q} + 4'd1;
		ngather  = {gather_q[55:0], data_byte};
		cmd_push = 1'b0;
		cmd.kind = CMD_PIXEL;
		cmd.data = ngather;
		if (accept) begin
			if (operation == OP_PAL_WRITE) begin
				cmd_push = 1'b1;
				cmd.kind = CMD_PAL_WR;
				cmd.data = {24'd0, palette_index, palette_rgba};
			end else if (sub_byte) begin
				cmd_push = 1'b1;
				cmd.kind = CMD_SUBBYTE;
				cmd.data = {56'd0, data_byte};
			end else if (ncount >= bpp) begin
				cmd_push = 1'b1;
			end
		end
	end

	// Gather bytes of a wide pixel; drop the partial pixel on a sub-byte byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gather_q <= '0;
			gcount_q <= '0;
		end else if (accept && operation == OP_ROW_BYTE) begin
			if (sub_byte || ncount >= bpp) begin
				gather_q <= '0;
				gcount_q <= '0;
			end else begin
				gather_q <= ngather;
				gcount_q <= ncount[2:0];
			end
		end
	end

endmodule

/* src/pspu_cmd_queue.sv */
module pspu_cmd_queue import pspu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic full,
	output logic empty
);

	cmd_t                  mem_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wptr_q;
	logic [CMDQ_PTR_W-1:0] rptr_q;
	logic [CMDQ_PTR_W:0]   count_q;

	assign full    = (count_q == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd_en) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + (CMDQ_PTR_W+1)'(wr_en) - (CMDQ_PTR_W+1)'(rd_en);
		end
	end

endmodule

/* src/pspu_back.sv */
module pspu_back import pspu_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  cmd_t                cmd,
	input  logic                cmd_empty,
	output logic                cmd_pop,
	input  logic [OUTQ_PTR_W:0] out_count,
	output logic                pix_valid,
	output pix_t                pix
);

	function automatic logic [7:0] to8(input logic [15:0] v);
		logic [24:0] t;
		t = ({9'd0, v} << 8) - {9'd0, v} + 25'd32895;
		return t[23:16];
	endfunction

	logic [31:0] pal_mem [PAL_DEPTH];
	logic [31:0] pal_rd_q;

	logic [15:0] pixels_done_q;
	logic        sub_active_q;
	logic [7:0]  sub_shift_q;
	logic [3:0]  sub_left_q;

	logic        valid_s1;
	logic        use_pal_s1;
	logic        pal_ok_s1;
	logic        wide_s1;
	logic        swap_s1;
	logic        end_s1;
	logic [15:0] r_s1, g_s1, b_s1, a_s1;

	logic [2:0]  ct;
	logic [4:0]  d;
	logic        credit_ok;
	logic        issue;
	logic        row_end;
	logic [15:0] pd_inc;
	logic [7:0]  cur;
	logic [3:0]  left;
	logic [3:0]  v;
	logic [7:0]  gray8;
	logic [7:0]  key8;
	logic [7:0]  pal_idx;
	logic        use_pal;
	logic        pal_ok;
	logic        wide;
	logic        swap;
	logic        pal_we;
	logic        pal_re;
	logic [15:0] s0, s1, s2, s3;
	logic [15:0] nr, ng, nb, na;
	logic [15:0] amax;
	logic [15:0] kr, kg, kb;
	logic [1:0]  pos0, pos1, pos2, pos3;
	logic [2:0]  ch;
	logic        hit;

	function automatic logic [15:0] lane(input logic [63:0] gb, input logic wide16,
	                                     input logic [1:0] p);
		return wide16 ? gb[p*16 +: 16] : {8'd0, gb[p*8 +: 8]};
	endfunction

	always_comb begin
		ct        = eff_type(cfg.pix_type);
		d         = eff_depth(ct, cfg.sample_bits);
		wide      = (d == BD_16) && (ct != CT_PAL);
		swap      = cfg.swap_red_blue && (ct == CT_RGB || ct == CT_RGBA);
		credit_ok = ({1'b0, out_count} + (OUTQ_PTR_W+2)'(valid_s1))
		            < (OUTQ_PTR_W+2)'(OUTQ_DEPTH);
		pd_inc    = pixels_done_q + 16'd1;
		row_end   = (pd_inc == cfg.row_pixels);
		cur       = sub_active_q ? sub_shift_q : cmd.data[7:0];
		amax      = (d == BD_16) ? 16'hffff : 16'h00ff;
		kr        = (d == BD_16) ? cfg.key_red   : {8'd0, cfg.key_red[7:0]};
		kg        = (d == BD_16) ? cfg.key_green : {8'd0, cfg.key_green[7:0]};
		kb        = (d == BD_16) ? cfg.key_blue  : {8'd0, cfg.key_blue[7:0]};
		// Take the next sample from the top of the byte; scale by bit replication
		case (d)
			BD_1: begin
				v     = {3'd0, cur[7]};
				left  = sub_active_q ? sub_left_q : 4'd8;
				gray8 = {8{cur[7]}};
				key8  = {8{cfg.key_red[0]}};
			end
			BD_2: begin
				v     = {2'd0, cur[7:6]};
				left  = sub_active_q ? sub_left_q : 4'd4;
				gray8 = {4{cur[7:6]}};
				key8  = {4{cfg.key_red[1:0]}};
			end
			default: begin
				v     = cur[7:4];
				left  = sub_active_q ? sub_left_q : 4'd2;
				gray8 = {2{cur[7:4]}};
				key8  = {2{cfg.key_red[3:0]}};
			end
		endcase
		case (ct)
			CT_RGB:  ch = 3'd3;
			CT_GA:   ch = 3'd2;
			CT_RGBA: ch = 3'd4;
			default: ch = 3'd1;
		endcase
		pos0 = 2'(ch - 3'd1);
		pos1 = 2'(ch - 3'd2);
		pos2 = 2'(ch - 3'd3);
		pos3 = 2'(ch - 3'd4);
		s0   = lane(cmd.data, d == BD_16, pos0);
		s1   = lane(cmd.data, d == BD_16, pos1);
		s2   = lane(cmd.data, d == BD_16, pos2);
		s3   = lane(cmd.data, d == BD_16, pos3);

		issue   = 1'b0;
		cmd_pop = 1'b0;
		pal_we  = 1'b0;
		use_pal = 1'b0;
		pal_idx = cmd.data[7:0];
		hit     = 1'b0;
		nr      = s0;
		ng      = s0;
		nb      = s0;
		na      = amax;
		case (cmd.kind)
			CMD_PAL_WR: begin
				cmd_pop = !cmd_empty;
				pal_idx = cmd.data[39:32];
				pal_we  = !cmd_empty;
			end
			CMD_SUBBYTE: begin
				issue   = !cmd_empty && credit_ok;
				cmd_pop = issue && (row_end || left == 4'd1);
				if (ct == CT_GRAY) begin
					hit = cfg.key_enable && (gray8 == key8);
					nr  = {8'd0, gray8};
					ng  = {8'd0, gray8};
					nb  = {8'd0, gray8};
					na  = hit ? 16'd0 : 16'd255;
				end else begin
					use_pal = 1'b1;
					pal_idx = {4'd0, v};
				end
			end
			CMD_PIXEL: begin
				issue   = !cmd_empty && credit_ok;
				cmd_pop = issue;
				case (ct)
					CT_PAL: begin
						use_pal = 1'b1;
						pal_idx = s0[7:0];
					end
					CT_GA: begin
						na = s1;
					end
					CT_RGB: begin
						hit = cfg.key_enable && s0 == kr && s1 == kg && s2 == kb;
						ng  = s1;
						nb  = s2;
						na  = hit ? 16'd0 : amax;
					end
					CT_RGBA: begin
						ng = s1;
						nb = s2;
						na = s3;
					end
					default: begin
						hit = cfg.key_enable && s0 == kr;
						na  = hit ? 16'd0 : amax;
					end
				endcase
			end
			default: begin
				cmd_pop = !cmd_empty;
			end
		endcase
		pal_ok = ({1'b0, pal_idx} < 9'(PAL_DEPTH));
		pal_re = issue && use_pal && pal_ok;
	end

	// Palette store: one write or one read per cycle, read data registered
	always_ff @(posedge clk) begin
		if (pal_we && pal_ok) begin
			pal_mem[pal_idx[PAL_IDX_W-1:0]] <= cmd.data[31:0];
		end
		if (pal_re) begin
			pal_rd_q <= pal_mem[pal_idx[PAL_IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_done_q <= '0;
			sub_active_q  <= 1'b0;
			sub_shift_q   <= '0;
			sub_left_q    <= '0;
			valid_s1      <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (issue) begin
				pixels_done_q <= row_end ? 16'd0 : pd_inc;
			end
			if (issue && cmd.kind == CMD_SUBBYTE) begin
				if (cmd_pop) begin
					sub_active_q <= 1'b0;
				end else begin
					sub_active_q <= 1'b1;
					sub_shift_q  <= 8'(cur << d);
					sub_left_q   <= left - 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			use_pal_s1 <= use_pal;
			pal_ok_s1  <= pal_ok;
			wide_s1    <= wide;
			swap_s1    <= swap;
			end_s1     <= row_end;
			r_s1       <= nr;
			g_s1       <= ng;
			b_s1       <= nb;
			a_s1       <= na;
		end
	end

	// Stage 2: palette lookup result or sample scaling, then channel order
	always_comb begin
		logic [31:0] e;
		logic [7:0]  r8, g8, b8, a8;
		e = pal_ok_s1 ? pal_rd_q : 32'd0;
		if (use_pal_s1) begin
			r8 = e[31:24];
			g8 = e[23:16];
			b8 = e[15:8];
			a8 = e[7:0];
		end else if (wide_s1) begin
			r8 = to8(r_s1);
			g8 = to8(g_s1);
			b8 = to8(b_s1);
			a8 = to8(a_s1);
		end else begin
			r8 = r_s1[7:0];
			g8 = g_s1[7:0];
			b8 = b_s1[7:0];
			a8 = a_s1[7:0];
		end
		pix_valid   = valid_s1;
		pix.red     = swap_s1 ? b8 : r8;
		pix.green   = g8;
		pix.blue    = swap_s1 ? r8 : b8;
		pix.alpha   = a8;
		pix.row_end = end_s1;
	end

endmodule

/* src/pspu_out_queue.sv */
module pspu_out_queue import pspu_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  pix_t                wr_data,
	input  logic                rd_en,
	output pix_t                rd_data,
	output logic                empty,
	output logic [OUTQ_PTR_W:0] count
);

	pix_t                  mem_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wptr_q;
	logic [OUTQ_PTR_W-1:0] rptr_q;
	logic [OUTQ_PTR_W:0]   count_q;

	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd_en) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + (OUTQ_PTR_W+1)'(wr_en) - (OUTQ_PTR_W+1)'(rd_en);
		end
	end

endmodule

/* src/png_scanline_pixel_unpack.sv */
// PNG row unpacker: takes unfiltered PNG row bytes (operation 1) and palette
// writes (operation 0) through a push/full queue port and returns 8-bit RGBA
// pixels through an empty/pop queue port. Gray, RGB, palette, gray+alpha and
// RGBA at depths 1, 2, 4, 8 and 16 are supported; 16-bit samples round to 8
// bits, sub-byte gray scales to full range, a single-color key clears alpha
// for gray and RGB, and red/blue can be swapped for RGB types. A row ends after
// row_pixels pixels (0 means 65536) and the unused bits of its last byte are
// dropped. Rate: one input transaction per cycle while the command queue has
// room; the pixel issue stage gives one pixel per cycle while the result
// queue has room, so a sub-byte row byte holds it for its 8/depth samples
// (fewer at row end) and a palette write takes a turn too; a byte that only
// adds to a partly gathered pixel at depth 8 or 16 costs it nothing. Palette
// entries read before being written return undefined data. Write
// configuration only while the block is idle.
module png_scanline_pixel_unpack import pspu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input queue side
	input  logic        push,
	output logic        full,
	input  logic        operation,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  palette_index,
	input  logic [31:0] palette_rgba,
	// result queue side
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic [7:0]  alpha_out,
	output logic        row_end
);

	cfg_t                cfg_q;
	logic                accept;
	logic                cmd_push;
	cmd_t                cmd_in;
	cmd_t                cmd_head;
	logic                cmd_empty;
	logic                cmd_pop;
	logic [OUTQ_PTR_W:0] out_count;
	logic                pix_valid;
	pix_t                pix;
	pix_t                out_head;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pix_type      <= CT_RGBA;
			cfg_q.sample_bits   <= BD_8;
			cfg_q.key_enable    <= 1'b0;
			cfg_q.key_red       <= '0;
			cfg_q.key_green     <= '0;
			cfg_q.key_blue      <= '0;
			cfg_q.swap_red_blue <= 1'b0;
			cfg_q.row_pixels    <= 16'd1;
		end else if (cfg_write) begin
			case (cfg_idx_t'(cfg_index))
				CFG_COLOR_TYPE: cfg_q.pix_type      <= cfg_data[2:0];
				CFG_BIT_DEPTH:  cfg_q.sample_bits   <= cfg_data[4:0];
				CFG_KEY_ENABLE: cfg_q.key_enable    <= cfg_data[0];
				CFG_KEY_RED:    cfg_q.key_red       <= cfg_data;
				CFG_KEY_GREEN:  cfg_q.key_green     <= cfg_data;
				CFG_KEY_BLUE:   cfg_q.key_blue      <= cfg_data;
				CFG_SWAP_RB:    cfg_q.swap_red_blue <= cfg_data[0];
				CFG_ROW_PIXELS: cfg_q.row_pixels    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold off the source whenever the command queue cannot take one more entry
	assign accept = push && !full;

	// Front: gather wide pixels, classify each transaction into a command
	pspu_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.accept        (accept),
		.operation     (operation),
		.data_byte     (data_byte),
		.palette_index (palette_index),
		.palette_rgba  (palette_rgba),
		.cmd_push      (cmd_push),
		.cmd           (cmd_in)
	);

	// Decouple front and back so each side stalls on its own
	pspu_cmd_queue u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.rd_en   (cmd_pop),
		.rd_data (cmd_head),
		.full    (full),
		.empty   (cmd_empty)
	);

	// Back: palette store, sample unpack, pixel issue and formatting
	pspu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.out_count (out_count),
		.pix_valid (pix_valid),
		.pix       (pix)
	);

	// Result queue; the back side only issues when a slot is reserved
	pspu_out_queue u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (pix_valid),
		.wr_data (pix),
		.rd_en   (pop && !empty),
		.rd_data (out_head),
		.empty   (empty),
		.count   (out_count)
	);

	assign red_out   = out_head.red;
	assign green_out = out_head.green;
	assign blue_out  = out_head.blue;
	assign alpha_out = out_head.alpha;
	assign row_end   = out_head.row_end;

endmodule
